// ===== sv/msp_pkg.sv =====
package msp_pkg;

  // Framing characters
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_V1    = 8'h4D;  // 'M'
  localparam logic [7:0] CH_V2    = 8'h58;  // 'X'
  localparam logic [7:0] CH_REQ   = 8'h3C;  // '<'
  localparam logic [7:0] CH_RSP   = 8'h3E;  // '>'
  localparam logic [7:0] CH_ERR   = 8'h21;  // '!'
  localparam logic [7:0] CH_ESC   = 8'hFF;  // jumbo length / tunnel command

  // Message type codes
  localparam logic [1:0] TY_REQ = 2'd0;
  localparam logic [1:0] TY_RSP = 2'd1;
  localparam logic [1:0] TY_ERR = 2'd2;

  // Frame version codes
  localparam logic [2:0] VER_V1       = 3'd0;
  localparam logic [2:0] VER_V1_JUMBO = 3'd1;
  localparam logic [2:0] VER_V2       = 3'd2;
  localparam logic [2:0] VER_V2O1     = 3'd3;
  localparam logic [2:0] VER_V2O1_J   = 3'd4;

  // Result kinds
  localparam logic EV_PAYLOAD = 1'b0;
  localparam logic EV_FRAME   = 1'b1;

  // Register word index (paddr[2])
  localparam logic REG_REQUESTS_ONLY = 1'b0;

  typedef struct packed {
    logic        event_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] command_code;
    logic [1:0]  message_type;
    logic [2:0]  frame_version;
    logic [7:0]  frame_flag;
    logic [15:0] frame_length;
    logic [7:0]  received_checksum;
  } msp_result_t;

endpackage

// ===== sv/msp_cfg_regs.sv =====
module msp_cfg_regs import msp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        requests_only_o
);

  logic requests_only_q, requests_only_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_REQUESTS_ONLY);

  always_comb begin
    requests_only_d = requests_only_q;
    if (wr_en) begin
      requests_only_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      requests_only_q <= 1'b1;
    end else begin
      requests_only_q <= requests_only_d;
    end
  end

  // Low two address bits are the byte offset within the word
  assign prdata = (paddr[2] == REG_REQUESTS_ONLY) ? {31'd0, requests_only_q} : 32'd0;
  assign requests_only_o = requests_only_q;

endmodule

// ===== sv/msp_fsm.sv =====
module msp_fsm import msp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  byte_i,
  input  logic        requests_only_i,
  output logic        res_valid_o,
  output msp_result_t res_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_TYPE_V1, ST_LEN_V1, ST_JLEN_LO, ST_JLEN_HI,
    ST_CMD_V1, ST_PAY_V1, ST_FLAG_T, ST_CMDLO_T, ST_CMDHI_T, ST_LENLO_T,
    ST_LENHI_T, ST_PAY_T, ST_INNER_CK_T, ST_CK_V1, ST_TYPE_V2, ST_FLAG_V2,
    ST_CMDLO_V2, ST_CMDHI_V2, ST_LENLO_V2, ST_LENHI_V2, ST_PAY_V2, ST_CK_V2
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] count_q, count_d;
  logic [15:0] length_q, length_d;
  logic [15:0] command_q, command_d;
  logic [1:0]  type_q, type_d;
  logic [2:0]  version_q, version_d;
  logic [7:0]  flag_q, flag_d;

  logic        ty_ok;
  logic [1:0]  ty_code;
  logic [15:0] count_inc;
  logic [15:0] len_full;
  logic        last_pay;
  logic        pass_frame;

  always_comb begin
    unique case (byte_i)
      CH_REQ: begin
        ty_ok   = 1'b1;
        ty_code = TY_REQ;
      end
      CH_RSP: begin
        ty_ok   = 1'b1;
        ty_code = TY_RSP;
      end
      CH_ERR: begin
        ty_ok   = 1'b1;
        ty_code = TY_ERR;
      end
      default: begin
        ty_ok   = 1'b0;
        ty_code = TY_ERR;
      end
    endcase
  end

  assign count_inc  = count_q + 16'd1;
  assign len_full   = {byte_i, length_q[7:0]};
  assign last_pay   = (count_inc >= length_q);
  assign pass_frame = !(requests_only_i && (type_q != TY_REQ));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    length_d    = length_q;
    command_d   = command_q;
    type_d      = type_q;
    version_d   = version_q;
    flag_d      = flag_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      unique case (state_q)
        ST_IDLE: begin
          if (byte_i == CH_START) begin
            state_d = ST_START;
          end
        end
        ST_START: begin
          if (byte_i == CH_V1) begin
            state_d = ST_TYPE_V1;
          end else if (byte_i == CH_V2) begin
            state_d = ST_TYPE_V2;
          end else begin
            state_d = ST_IDLE;
          end
        end
        ST_TYPE_V1: begin
          if (ty_ok) begin
            type_d  = ty_code;
            flag_d  = 8'd0;
            state_d = ST_LEN_V1;
          end else begin
            state_d = ST_IDLE;
          end
        end
        ST_LEN_V1: begin
          if (byte_i == CH_ESC) begin
            version_d = VER_V1_JUMBO;
            state_d   = ST_JLEN_LO;
          end else begin
            length_d  = {8'd0, byte_i};
            version_d = VER_V1;
            state_d   = ST_CMD_V1;
          end
        end
        ST_JLEN_LO: begin
          length_d = {8'd0, byte_i};
          state_d  = ST_JLEN_HI;
        end
        ST_JLEN_HI: begin
          length_d = len_full;
          state_d  = ST_CMD_V1;
        end
        ST_CMD_V1: begin
          if (byte_i == CH_ESC) begin
            version_d = (version_q == VER_V1) ? VER_V2O1 : VER_V2O1_J;
            state_d   = ST_FLAG_T;
          end else begin
            command_d = {8'd0, byte_i};
            count_d   = 16'd0;
            state_d   = (length_q != 16'd0) ? ST_PAY_V1 : ST_CK_V1;
          end
        end
        ST_FLAG_T, ST_FLAG_V2: begin
          flag_d  = byte_i;
          state_d = (state_q == ST_FLAG_T) ? ST_CMDLO_T : ST_CMDLO_V2;
        end
        ST_CMDLO_T, ST_CMDLO_V2: begin
          command_d = {8'd0, byte_i};
          state_d   = (state_q == ST_CMDLO_T) ? ST_CMDHI_T : ST_CMDHI_V2;
        end
        ST_CMDHI_T, ST_CMDHI_V2: begin
          command_d = {byte_i, command_q[7:0]};
          state_d   = (state_q == ST_CMDHI_T) ? ST_LENLO_T : ST_LENLO_V2;
        end
        ST_LENLO_T, ST_LENLO_V2: begin
          length_d = {8'd0, byte_i};
          state_d  = (state_q == ST_LENLO_T) ? ST_LENHI_T : ST_LENHI_V2;
        end
        ST_LENHI_T: begin
          length_d = len_full;
          count_d  = 16'd0;
          state_d  = (len_full != 16'd0) ? ST_PAY_T : ST_INNER_CK_T;
        end
        ST_LENHI_V2: begin
          length_d = len_full;
          count_d  = 16'd0;
          state_d  = (len_full != 16'd0) ? ST_PAY_V2 : ST_CK_V2;
        end
        ST_PAY_V1, ST_PAY_T, ST_PAY_V2: begin
          res_valid_o         = 1'b1;
          res_o.event_kind    = EV_PAYLOAD;
          res_o.payload_byte  = byte_i;
          res_o.payload_index = count_q;
          count_d             = count_inc;
          if (last_pay) begin
            unique case (state_q)
              ST_PAY_V1: state_d = ST_CK_V1;
              ST_PAY_T:  state_d = ST_INNER_CK_T;
              default:   state_d = ST_CK_V2;
            endcase
          end
        end
        ST_INNER_CK_T: begin
          state_d = ST_CK_V1;
        end
        ST_CK_V1, ST_CK_V2: begin
          // Checksum is forwarded as received; drop non-requests when filtering
          state_d                 = ST_IDLE;
          res_valid_o             = pass_frame;
          res_o.event_kind        = EV_FRAME;
          res_o.command_code      = command_q;
          res_o.message_type      = type_q;
          res_o.frame_version     = version_q;
          res_o.frame_flag        = flag_q;
          res_o.frame_length      = length_q;
          res_o.received_checksum = byte_i;
        end
        ST_TYPE_V2: begin
          version_d = VER_V2;
          if (ty_ok) begin
            type_d  = ty_code;
            state_d = ST_FLAG_V2;
          end else begin
            state_d = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= 16'd0;
      length_q  <= 16'd0;
      command_q <= 16'd0;
      type_q    <= TY_ERR;
      version_q <= VER_V2;
      flag_q    <= 8'd0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      length_q  <= length_d;
      command_q <= command_d;
      type_q    <= type_d;
      version_q <= version_d;
      flag_q    <= flag_d;
    end
  end

`ifndef ASSERT_OFF
  a_pay_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.event_kind == EV_PAYLOAD)) |-> (res_o.payload_index < length_q))
    else $error("payload index beyond declared length");

  a_filter_requests: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.event_kind == EV_FRAME) && requests_only_i)
      |-> (res_o.message_type == TY_REQ))
    else $error("non-request frame end passed the filter");
`endif

endmodule

// ===== sv/msp_out_buf.sv =====
module msp_out_buf import msp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  msp_result_t push_data_i,
  output logic        space_o,
  output logic        out_valid_o,
  output msp_result_t out_data_o,
  input  logic        out_ready_i
);

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  msp_result_t out_data_q, out_data_d;
  msp_result_t skid_data_q, skid_data_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_ready_i) begin
      // Output stage frees up: advance skid, or take the new beat directly
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = push_i;
        skid_data_d  = push_data_i;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      // Output stalled: hold the new beat in the skid stage
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a beat while the output stage is empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("beat pushed into a full buffer");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && push_i) |=> skid_valid_q)
    else $error("beat lost while the output was stalled");
`endif

endmodule

// ===== sv/msp_frame_parser.sv =====
// Byte-serial frame parser for MultiWii Serial Protocol V1, V1 jumbo, V2 and
// V2-over-V1 frames. One received byte is taken per beat on rx_byte_i, and a
// byte may be accepted in every clock cycle while in_ready_o is high: the
// framing state machine updates in the cycle of acceptance and its result (a
// payload byte with its index, or a frame-end record with command, type,
// version, flag, length and the raw checksum) is registered in the result
// register, or in the skid register while the output stalls. This two-entry
// stage lets a byte be accepted while one result waits; in_ready_o drops only
// when both entries are full. Header, start and checksum bytes other than the
// last give no result; the checksum is not verified. With requests_only set
// (the reset value) frame ends of responses and errors are dropped. Register 0
// at address 0 bit 0 is requests_only; write it only while the parser is idle.
module msp_frame_parser import msp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        event_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [15:0] command_code_o,
  output logic [1:0]  message_type_o,
  output logic [2:0]  frame_version_o,
  output logic [7:0]  frame_flag_o,
  output logic [15:0] frame_length_o,
  output logic [7:0]  received_checksum_o
);

  logic        requests_only;
  logic        accept;
  logic        res_valid;
  logic        space;
  msp_result_t res;
  msp_result_t out_data;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  msp_cfg_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .requests_only_o(requests_only)
  );

  msp_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .byte_i         (rx_byte_i),
    .requests_only_i(requests_only),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  msp_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data),
    .out_ready_i(out_ready_i)
  );

  assign event_kind_o        = out_data.event_kind;
  assign payload_byte_o      = out_data.payload_byte;
  assign payload_index_o     = out_data.payload_index;
  assign command_code_o      = out_data.command_code;
  assign message_type_o      = out_data.message_type;
  assign frame_version_o     = out_data.frame_version;
  assign frame_flag_o        = out_data.frame_flag;
  assign frame_length_o      = out_data.frame_length;
  assign received_checksum_o = out_data.received_checksum;

endmodule

// ===== tb/msp_frame_parser_tb.sv =====
module msp_frame_parser_tb import msp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [4:0] {
    PS_IDLE, PS_START, PS_TYPE_V1, PS_LEN_V1, PS_JLEN_LO, PS_JLEN_HI, PS_CMD_V1,
    PS_PAY_V1, PS_FLAG_T, PS_CMDLO_T, PS_CMDHI_T, PS_LENLO_T, PS_LENHI_T, PS_PAY_T,
    PS_INNER_CK_T, PS_CK_V1, PS_TYPE_V2, PS_FLAG_V2, PS_CMDLO_V2, PS_CMDHI_V2,
    PS_LENLO_V2, PS_LENHI_V2, PS_PAY_V2, PS_CK_V2
  } parse_state_e;

  typedef enum int {
    FK_V1, FK_V1_JUMBO, FK_V2, FK_TUNNEL, FK_TUNNEL_JUMBO
  } frame_kind_e;

  class msp_frame_checker;
    bit           req_only;
    parse_state_e st;
    logic [15:0]  pay_cnt;
    logic [15:0]  len;
    logic [15:0]  cmd;
    logic [1:0]   ty;
    logic [2:0]   ver;
    logic [7:0]   flag;
    msp_result_t  expected_events[$];
    int           errors;
    int           bytes_in;
    int           payloads_seen;
    int           frames_seen;

    function new();
      req_only = 1'b1;
      st       = PS_IDLE;
      pay_cnt  = '0;
      len      = '0;
      cmd      = '0;
      ty       = TY_ERR;
      ver      = VER_V2;
      flag     = '0;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function bit type_code(logic [7:0] c, output logic [1:0] t);
      type_code = 1'b1;
      t = TY_ERR;
      case (c)
        CH_REQ: t = TY_REQ;
        CH_RSP: t = TY_RSP;
        CH_ERR: t = TY_ERR;
        default: type_code = 1'b0;
      endcase
    endfunction

    // Payload beat: index from the first payload byte, leave after len bytes
    function void payload_beat(logic [7:0] c, parse_state_e nxt_st, ref msp_result_t r);
      logic [15:0] nxt;
      nxt = pay_cnt + 16'd1;
      r.event_kind    = EV_PAYLOAD;
      r.payload_byte  = c;
      r.payload_index = pay_cnt;
      if (nxt >= len) st = nxt_st;
      pay_cnt = nxt;
    endfunction

    function void note_rx_byte(logic [7:0] c);
      msp_result_t r;
      logic [1:0]  t;
      bit          hit;
      r = '0;
      hit = 1'b0;
      bytes_in++;
      case (st)
        PS_IDLE: if (c == CH_START) st = PS_START;
        PS_START: begin
          if (c == CH_V1) st = PS_TYPE_V1;
          else if (c == CH_V2) st = PS_TYPE_V2;
          else st = PS_IDLE;
        end
        PS_TYPE_V1: begin
          if (type_code(c, t)) begin
            ty = t;
            flag = '0;
            st = PS_LEN_V1;
          end else begin
            st = PS_IDLE;
          end
        end
        PS_LEN_V1: begin
          if (c == CH_ESC) begin
            ver = VER_V1_JUMBO;
            st = PS_JLEN_LO;
          end else begin
            len = {8'h00, c};
            ver = VER_V1;
            st = PS_CMD_V1;
          end
        end
        PS_JLEN_LO: begin
          len = {8'h00, c};
          st = PS_JLEN_HI;
        end
        PS_JLEN_HI: begin
          len = {c, len[7:0]};
          st = PS_CMD_V1;
        end
        PS_CMD_V1: begin
          if (c == CH_ESC) begin
            ver = (ver == VER_V1) ? VER_V2O1 : VER_V2O1_J;
            st = PS_FLAG_T;
          end else begin
            cmd = {8'h00, c};
            pay_cnt = '0;
            st = (len != 0) ? PS_PAY_V1 : PS_CK_V1;
          end
        end
        PS_PAY_V1: begin
          payload_beat(c, PS_CK_V1, r);
          hit = 1'b1;
        end
        PS_FLAG_T: begin
          flag = c;
          st = PS_CMDLO_T;
        end
        PS_CMDLO_T: begin
          cmd = {8'h00, c};
          st = PS_CMDHI_T;
        end
        PS_CMDHI_T: begin
          cmd = {c, cmd[7:0]};
          st = PS_LENLO_T;
        end
        PS_LENLO_T: begin
          len = {8'h00, c};
          st = PS_LENHI_T;
        end
        PS_LENHI_T: begin
          len = {c, len[7:0]};
          pay_cnt = '0;
          st = (len != 0) ? PS_PAY_T : PS_INNER_CK_T;
        end
        PS_PAY_T: begin
          payload_beat(c, PS_INNER_CK_T, r);
          hit = 1'b1;
        end
        PS_INNER_CK_T: st = PS_CK_V1;
        PS_CK_V1, PS_CK_V2: begin
          st = PS_IDLE;
          // drop responses and errors while the filter is on
          if (!(req_only && ty != TY_REQ)) begin
            r.event_kind        = EV_FRAME;
            r.command_code      = cmd;
            r.message_type      = ty;
            r.frame_version     = ver;
            r.frame_flag        = flag;
            r.frame_length      = len;
            r.received_checksum = c;
            hit = 1'b1;
          end
        end
        PS_TYPE_V2: begin
          ver = VER_V2;
          if (type_code(c, t)) begin
            ty = t;
            st = PS_FLAG_V2;
          end else begin
            st = PS_IDLE;
          end
        end
        PS_FLAG_V2: begin
          flag = c;
          st = PS_CMDLO_V2;
        end
        PS_CMDLO_V2: begin
          cmd = {8'h00, c};
          st = PS_CMDHI_V2;
        end
        PS_CMDHI_V2: begin
          cmd = {c, cmd[7:0]};
          st = PS_LENLO_V2;
        end
        PS_LENLO_V2: begin
          len = {8'h00, c};
          st = PS_LENHI_V2;
        end
        PS_LENHI_V2: begin
          len = {c, len[7:0]};
          pay_cnt = '0;
          st = (len != 0) ? PS_PAY_V2 : PS_CK_V2;
        end
        PS_PAY_V2: begin
          payload_beat(c, PS_CK_V2, r);
          hit = 1'b1;
        end
        default: st = PS_IDLE;
      endcase
      if (hit) expected_events.push_back(r);
    endfunction

    function void cmp(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_event(msp_result_t got);
      msp_result_t want;
      if (expected_events.size() == 0) begin
        $error("result with nothing expected: event_kind %0d", got.event_kind);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      cmp("event_kind", 16'(want.event_kind), 16'(got.event_kind));
      cmp("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      cmp("payload_index", want.payload_index, got.payload_index);
      cmp("command_code", want.command_code, got.command_code);
      cmp("message_type", 16'(want.message_type), 16'(got.message_type));
      cmp("frame_version", 16'(want.frame_version), 16'(got.frame_version));
      cmp("frame_flag", 16'(want.frame_flag), 16'(got.frame_flag));
      cmp("frame_length", want.frame_length, got.frame_length);
      cmp("received_checksum", 16'(want.received_checksum), 16'(got.received_checksum));
      if (want.event_kind == EV_FRAME) frames_seen++;
      else payloads_seen++;
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        event_kind_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] payload_index_o;
  logic [15:0] command_code_o;
  logic [1:0]  message_type_o;
  logic [2:0]  frame_version_o;
  logic [7:0]  frame_flag_o;
  logic [15:0] frame_length_o;
  logic [7:0]  received_checksum_o;

  msp_frame_checker sb = new();

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int sink_hold     = 0;
  int frame_bytes   = 0;

  msp_frame_parser u_top (.*);

  always #2 clk_i = ~clk_i;

  // Receiver: random back-pressure, or a long hold when one is requested
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      out_ready_i <= 1'b0;
      sink_hold--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_mon
    msp_result_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.event_kind        = event_kind_o;
      seen.payload_byte      = payload_byte_o;
      seen.payload_index     = payload_index_o;
      seen.command_code      = command_code_o;
      seen.message_type      = message_type_o;
      seen.frame_version     = frame_version_o;
      seen.frame_flag        = frame_flag_o;
      seen.frame_length      = frame_length_o;
      seen.received_checksum = received_checksum_o;
      sb.check_event(seen);
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Called just after a rising edge; returns just after the edge that takes the beat
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_rx_byte(b);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // header bytes give no result, so allow the pipeline to empty
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_requests_only(input bit v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_REQUESTS_ONLY, 2'b00};
    pwdata  <= {31'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.req_only = v;
  endtask

  task automatic send_frame(input frame_kind_e kind, input int unsigned len, input bit cut);
    logic [7:0]  bytes[$];
    logic [7:0]  tch;
    int unsigned keep;
    int          r;
    r = $urandom_range(3);
    tch = (r < 2) ? CH_REQ : ((r == 2) ? CH_RSP : CH_ERR);
    bytes.push_back(CH_START);
    bytes.push_back((kind == FK_V2) ? CH_V2 : CH_V1);
    bytes.push_back(tch);
    case (kind)
      FK_V1: begin
        bytes.push_back(8'(len));
        bytes.push_back(8'($urandom_range(254)));
      end
      FK_V1_JUMBO: begin
        bytes.push_back(CH_ESC);
        bytes.push_back(8'(len));
        bytes.push_back(8'(len >> 8));
        bytes.push_back(8'($urandom_range(254)));
      end
      FK_TUNNEL: begin
        bytes.push_back(8'($urandom_range(254)));
        bytes.push_back(CH_ESC);
      end
      FK_TUNNEL_JUMBO: begin
        bytes.push_back(CH_ESC);
        bytes.push_back(8'($urandom));
        bytes.push_back(8'($urandom));
        bytes.push_back(CH_ESC);
      end
      default: ;
    endcase
    if (kind != FK_V1 && kind != FK_V1_JUMBO) begin
      bytes.push_back(8'($urandom));
      bytes.push_back(8'($urandom));
      bytes.push_back(8'($urandom));
      bytes.push_back(8'(len));
      bytes.push_back(8'(len >> 8));
    end
    repeat (len) bytes.push_back(8'($urandom));
    if (kind == FK_TUNNEL || kind == FK_TUNNEL_JUMBO) bytes.push_back(8'($urandom));
    bytes.push_back(8'($urandom));
    keep = cut ? $urandom_range(1, bytes.size() - 1) : bytes.size();
    for (int i = 0; i < keep; i++) send_byte(bytes[i]);
    if (!cut) frame_bytes += keep;
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input frame_kind_e big_kind,
                           input int unsigned big_len, input int target);
    int          pick;
    int unsigned len;
    frame_kind_e kind;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    frame_bytes   = 0;
    send_frame(big_kind, big_len, 1'b0);
    while (frame_bytes < target) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // noise: loose bytes with the odd start character
        repeat ($urandom_range(1, 6))
          send_byte(($urandom_range(3) == 0) ? CH_START : 8'($urandom));
      end else begin
        kind = frame_kind_e'($urandom_range(FK_V1, FK_TUNNEL_JUMBO));
        len  = ($urandom_range(19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        send_frame(kind, len, pick < 20);
      end
    end
  endtask

  initial begin
    logic [7:0] directed [24];
    directed = '{
      CH_START, 8'h51,                                    // bad version byte
      CH_START, CH_V2, 8'h3F,                             // bad V2 type byte
      CH_START, CH_V1, CH_RSP, 8'h01, 8'h00, 8'hFF, 8'h00, // V1, one payload byte
      CH_START, CH_V1, CH_ERR, 8'h00, CH_ESC, 8'hFF, 8'hFF, 8'hFF,
      8'h00, 8'h00, 8'hAA, 8'hFF                          // tunnelled, zero length
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_requests_only(1'b0);
    src_idle_pct  = 9;
    sink_idle_pct = 62;
    foreach (directed[i]) send_byte(directed[i]);

    run_phase(9, 62, FK_V1, 254, 510);
    write_requests_only(1'b1);
    run_phase(62, 9, FK_V2, 300, 510);
    write_requests_only(1'b0);
    sink_hold = 300;
    run_phase(0, 0, FK_TUNNEL_JUMBO, 260, 510);

    drain();
    $display("Fed %0d bytes through all five frame kinds, truncated frames and noise;",
             sb.bytes_in);
    $display("checked %0d payload beats and %0d frame ends, request filter on and off.",
             sb.payloads_seen, sb.frames_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
